// File: hdl/mnps_pkg.sv
// Package for the mono note priority stack.
// Holds the request and result types, the action codes and the cell link types.
// No dependencies.
package mnps_pkg;

  localparam int HELD_W = 5;

  typedef logic [6:0] note_t;

  localparam logic REQ_OFF = 1'b0;
  localparam logic REQ_ON  = 1'b1;

  typedef enum logic [1:0] {
    PA_NONE  = 2'd0,
    PA_SNAP  = 2'd1,
    PA_GLIDE = 2'd2
  } pitch_act_t;

  typedef enum logic [1:0] {
    EA_NONE    = 2'd0,
    EA_ATTACK  = 2'd1,
    EA_RELEASE = 2'd2
  } env_act_t;

  typedef struct packed {
    logic  req_type;
    note_t note_number;
  } in_t;

  typedef struct packed {
    pitch_act_t        pitch_action;
    note_t             pitch_note;
    env_act_t          env_action;
    logic              gate_open;
    logic [HELD_W-1:0] held_notes;
    logic              note_dropped;
  } out_t;

  typedef struct packed {
    logic  accept;
    logic  wr_en;
    note_t note;
  } cell_ctl_t;

  typedef struct packed {
    logic  found;
    note_t tap;
  } cell_link_t;

endpackage

// File: hdl/mnps_cell.sv
// One slot of the note stack: compare, shift down from the neighbor above, or load.
// Depends on mnps_pkg.
module mnps_cell
  import mnps_pkg::*;
#(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  logic [CW-1:0]   cnt,
  input  logic [CW-1:0]   wr_idx,
  input  logic [CW-1:0]   tap_idx,
  input  note_t           above,
  input  cell_link_t      link_in,
  output note_t           slot,
  output cell_link_t      link_out
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  note_t slot_r;
  note_t slot_nxt;
  logic  match;
  logic  shift;

  always_comb begin
    match    = (slot_r == ctl.note) && (IDX_C < cnt);
    shift    = link_in.found | match;
    slot_nxt = slot_r;
    if (ctl.wr_en && (wr_idx == IDX_C)) begin
      slot_nxt = ctl.note;
    end else if (ctl.accept && shift) begin
      slot_nxt = above;
    end
    link_out.found = shift;
    link_out.tap   = link_in.tap | ((tap_idx == IDX_C) ? slot_nxt : '0);
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot = slot_r;

endmodule

// File: hdl/mono_note_priority_stack.sv
// Monophonic last-note-priority note stack: top level with control and result register.
// Depends on mnps_pkg and mnps_cell.
//
// Each key request (note on or note off) gives exactly one registered result, shown in the
// cycle after it is taken; a new request is taken every cycle as long as the result side
// keeps up. Held notes live in a row of STACK_DEPTH cells, oldest at the bottom; all
// cells compare the key against their slot at once, and the lowest match plus every
// cell above it shift down by one, so removal, append and the new top are resolved in
// the same cycle. A note-on with no room (full, key not held) is flagged dropped but opens
// the gate. Slots are not cleared at reset; only slots below the held count are used.
module mono_note_priority_stack
  import mnps_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int              CW      = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0]   DEPTH_C = CW'(STACK_DEPTH);

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic          gate_r;
  logic          gate_nxt;
  logic          out_valid_r;
  out_t          out_r;
  out_t          res;

  cell_ctl_t     ctl;
  cell_link_t    link  [0:STACK_DEPTH];
  note_t         slots [0:STACK_DEPTH];
  logic          accept;
  logic          is_on;
  logic [CW-1:0] cnt_rem;
  logic [CW-1:0] tap_idx;
  logic          room;
  logic [CW+HELD_W-1:0] held_ext;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_on    = (in_data.req_type == REQ_ON);

  assign link[0]            = '0;
  assign slots[STACK_DEPTH] = '0;

  assign cnt_rem = cnt_r - CW'(link[STACK_DEPTH].found);
  assign room    = cnt_rem < DEPTH_C;
  assign tap_idx = cnt_rem - CW'(1);

  assign ctl.accept = accept;
  assign ctl.wr_en  = accept && is_on && room;
  assign ctl.note   = in_data.note_number;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    mnps_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .cnt      (cnt_r),
      .wr_idx   (cnt_rem),
      .tap_idx  (tap_idx),
      .above    (slots[i+1]),
      .link_in  (link[i]),
      .slot     (slots[i]),
      .link_out (link[i+1])
    );
  end

  always_comb begin
    res          = '0;
    cnt_nxt      = cnt_rem;
    gate_nxt     = gate_r;
    if (is_on) begin
      gate_nxt         = 1'b1;
      cnt_nxt          = room ? (cnt_rem + CW'(1)) : cnt_rem;
      res.pitch_note   = in_data.note_number;
      res.pitch_action = gate_r ? PA_GLIDE : PA_SNAP;
      res.env_action   = gate_r ? EA_NONE : EA_ATTACK;
      res.note_dropped = !room;
    end else if (cnt_rem == '0) begin
      gate_nxt         = 1'b0;
      res.env_action   = EA_RELEASE;
    end else begin
      res.pitch_action = PA_GLIDE;
      res.pitch_note   = link[STACK_DEPTH].tap;
    end
    held_ext       = {{HELD_W{1'b0}}, cnt_nxt};
    res.gate_open  = gate_nxt;
    res.held_notes = held_ext[HELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      gate_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r  <= cnt_nxt;
        gate_r <= gate_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_gate_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    gate_r == (cnt_r != '0))
    else $error("gate flag disagrees with held count");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("held count above stack depth");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.note_dropped |-> cnt_r == DEPTH_C)
    else $error("note dropped while stack not full");

  a_idle_pitch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.pitch_action == PA_NONE) |-> out_r.pitch_note == '0)
    else $error("pitch note set without pitch action");

  a_on_opens_gate: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_on |=> gate_r)
    else $error("note on did not open the gate");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for mono_note_priority_stack: note requests with random idling and
// back-pressure, each result checked against a last-note-priority stack kept in the bench.
// Depends on mnps_pkg and the mono_note_priority_stack RTL.
module testbench;
  import mnps_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN    = 300;
  localparam int SETTLE      = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  note_t held_keys[$];
  bit    gate_held = 1'b0;
  out_t  pending_results[$];

  bit    idle_on = 1'b1;
  bit    rx_hold = 1'b0;
  event  hold_off_req;

  int cycle_cnt = 0;
  int fail_cnt = 0;
  int req_cnt = 0;
  int result_cnt = 0;
  int drop_cnt = 0;
  int release_cnt = 0;
  int glide_cnt = 0;

  mono_note_priority_stack #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  function automatic out_t predict_key(in_t req);
    out_t res;
    int   hit;
    res = '0;
    res.pitch_action = PA_NONE;
    res.env_action = EA_NONE;
    hit = -1;
    foreach (held_keys[i]) begin
      if (hit < 0 && held_keys[i] == req.note_number) hit = i;
    end
    if (hit >= 0) held_keys.delete(hit);
    if (req.req_type == REQ_ON) begin
      if (held_keys.size() < STACK_DEPTH) held_keys.push_back(req.note_number);
      else res.note_dropped = 1'b1;
      res.pitch_note = req.note_number;
      if (gate_held) begin
        res.pitch_action = PA_GLIDE;
      end else begin
        res.pitch_action = PA_SNAP;
        res.env_action = EA_ATTACK;
      end
      gate_held = 1'b1;
    end else if (held_keys.size() == 0) begin
      res.env_action = EA_RELEASE;
      gate_held = 1'b0;
    end else begin
      res.pitch_action = PA_GLIDE;
      res.pitch_note = held_keys[held_keys.size()-1];
    end
    res.gate_open = gate_held;
    res.held_notes = HELD_W'(held_keys.size());
    return res;
  endfunction

  task automatic report_fail(string what, out_t want, out_t got);
    if (fail_cnt < 10)
      $display("mismatch at cycle %0d: %s expected %p actual %p", cycle_cnt, what, want, got);
    fail_cnt++;
  endtask

  task automatic check_result(out_t got);
    out_t  want;
    string diff;
    diff = "";
    if (pending_results.size() == 0) begin
      report_fail("result with nothing pending;", '0, got);
    end else begin
      want = pending_results.pop_front();
      result_cnt++;
      if (want.note_dropped) drop_cnt++;
      if (want.env_action == EA_RELEASE) release_cnt++;
      if (want.pitch_action == PA_GLIDE) glide_cnt++;
      if (got.pitch_action !== want.pitch_action) diff = {diff, " pitch_action"};
      if (got.pitch_note !== want.pitch_note) diff = {diff, " pitch_note"};
      if (got.env_action !== want.env_action) diff = {diff, " env_action"};
      if (got.gate_open !== want.gate_open) diff = {diff, " gate_open"};
      if (got.held_notes !== want.held_notes) diff = {diff, " held_notes"};
      if (got.note_dropped !== want.note_dropped) diff = {diff, " note_dropped"};
      if (diff != "") report_fail({"fields", diff, ";"}, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    out_ready <= rx_hold ? 1'b0 : (!idle_on || $urandom_range(99) >= 29);
  end

  always begin
    @(hold_off_req);
    rx_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_req(logic kind, note_t note);
    in_t req;
    req.req_type = kind;
    req.note_number = note;
    while (idle_on && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_key(req));
    req_cnt++;
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic note_t pick_note();
    if ($urandom_range(1)) return note_t'($urandom_range(71, 48));
    return note_t'($urandom_range(127));
  endfunction

  task automatic test_basic_keys();
    send_req(REQ_OFF, 7'd5);
    send_req(REQ_ON, 7'd0);
    send_req(REQ_ON, 7'd127);
    send_req(REQ_ON, 7'd0);
    send_req(REQ_OFF, 7'd60);
    send_req(REQ_OFF, 7'd0);
    send_req(REQ_OFF, 7'd127);
    wait_all_results();
  endtask

  task automatic test_full_stack();
    for (int k = 0; k < STACK_DEPTH; k++) send_req(REQ_ON, note_t'(16 + 7 * k));
    send_req(REQ_ON, 7'd127);
    send_req(REQ_ON, 7'd16);
    send_req(REQ_OFF, 7'd3);
    send_req(REQ_OFF, 7'd51);
    wait_all_results();
  endtask

  task automatic test_random_play(int n, int on_pct);
    int    pick;
    logic  kind;
    note_t note;
    repeat (n) begin
      pick = $urandom_range(99);
      kind = REQ_OFF;
      if (pick < on_pct) begin
        kind = REQ_ON;
        note = pick_note();
      end else if (pick < 88 && held_keys.size() != 0) begin
        note = held_keys[$urandom_range(held_keys.size() - 1)];
      end else begin
        note = pick_note();
      end
      send_req(kind, note);
    end
  endtask

  task automatic test_full_rate();
    idle_on <= 1'b0;
    test_random_play(200, 50);
    idle_on <= 1'b1;
  endtask

  task automatic test_backpressure();
    -> hold_off_req;
    test_random_play(40, 55);
    while (rx_hold) @(posedge clk);
    wait_all_results();
  endtask

  task automatic test_release_all();
    while (held_keys.size() != 0)
      send_req(REQ_OFF, held_keys[$urandom_range(held_keys.size() - 1)]);
    wait_all_results();
  endtask

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_keys();
    test_full_stack();
    test_release_all();
    test_full_rate();
    test_random_play(300, 45);
    test_backpressure();
    test_random_play(300, 72);
    wait_all_results();
    test_random_play(150, 30);
    test_release_all();
    wait_all_results();
    $display("covered %0d requests, %0d results: %0d dropped, %0d glides, %0d releases",
             req_cnt, result_cnt, drop_cnt, glide_cnt, release_cnt);
    $display("including a full-rate stretch, a %0d-cycle output stall and drain pauses",
             HOLD_LEN);
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("%0d failures, %0d results still pending", fail_cnt, pending_results.size());
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
